/* src/phma_pkg.sv */
// Package: shared constants, types and the periodic axis distance for the halo assigner
`timescale 1ns / 1ps
`default_nettype none
package phma_pkg;
    localparam int DefMaxHalos    = 256;
    localparam int DefMaxSubhalos = 256;
    localparam int SlotLimit      = 256;
    localparam int HitDepth       = 256;
    localparam int CountW         = 9;
    localparam int CoordW         = 32;

    localparam logic [1:0] OP_LOAD_HALO = 2'd0;
    localparam logic [1:0] OP_LOAD_SUB  = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [1:0] REG_BOX  = 2'd0;
    localparam logic [1:0] REG_HALO = 2'd1;
    localparam logic [1:0] REG_SUB  = 2'd2;

    localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;
    localparam logic [8:0]  NoHalo = 9'h1FF;

    typedef struct packed {
        logic start;
        logic step_halo;
        logic step_sub;
        logic finish;
    } phma_cmd_t;

    typedef struct packed {
        logic halo_last;
        logic sub_last;
        logic halo_empty;
        logic sub_empty;
        logic have;
        logic pipe_busy;
    } phma_stat_t;

    function automatic logic [31:0] axis_dist(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] bx);
        logic [31:0] d;
        logic [32:0] d2;
        logic [31:0] r;
        begin
            d  = (a > b) ? (a - b) : (b - a);
            d2 = {d, 1'b0};
            r  = d;
            if (d2 > {1'b0, bx})
            begin
                r = (d > bx) ? (d - bx) : (bx - d);
            end
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* src/phma_ctrl.sv */
// Controller: sequences halo scan, subhalo scan and result transfer
`timescale 1ns / 1ps
`default_nettype none
module phma_ctrl
    import phma_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       query_go,
    input  wire phma_stat_t stat,
    input  wire logic       out_free,
    output phma_cmd_t       cmd,
    output logic            busy
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HALO  = 5'b00010,
        S_SUB   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   drain_sub_reg, drain_sub_next;

    always_comb
    begin
        state_next     = state_reg;
        drain_sub_next = drain_sub_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (query_go)
                begin
                    cmd.start      = 1'b1;
                    drain_sub_next = 1'b0;
                    state_next     = stat.halo_empty ? S_DRAIN : S_HALO;
                end
            end
            S_HALO:
            begin
                cmd.step_halo = 1'b1;
                if (stat.halo_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_SUB:
            begin
                cmd.step_sub = 1'b1;
                if (stat.sub_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    if (!drain_sub_reg && !stat.have && !stat.sub_empty)
                    begin
                        drain_sub_next = 1'b1;
                        state_next     = S_SUB;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            drain_sub_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_sub_reg <= drain_sub_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> state_reg == S_DONE) else $error("finish outside done");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg != S_IDLE) else $error("start did not leave idle");
endmodule
`default_nettype wire

/* src/phma_dp.sv */
// Datapath: entry tables, pipelined containment test, selection and hit counters
`timescale 1ns / 1ps
`default_nettype none
module phma_dp
    import phma_pkg::*;
#(
    parameter int MAX_HALOS    = DefMaxHalos,
    parameter int MAX_SUBHALOS = DefMaxSubhalos
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load_halo,
    input  wire logic        load_sub,
    input  wire logic [7:0]  entry_index,
    input  wire logic [31:0] x_coord,
    input  wire logic [31:0] y_coord,
    input  wire logic [31:0] z_coord,
    input  wire logic [31:0] radius,
    input  wire logic [31:0] mass_or_parent,
    input  wire logic [31:0] box_size,
    input  wire logic [8:0]  halo_count,
    input  wire logic [8:0]  subhalo_count,
    input  wire phma_cmd_t   cmd,
    output phma_stat_t       stat,
    output logic             res_found,
    output logic [8:0]       res_halo,
    output logic [31:0]      res_hits,
    output logic [31:0]      res_miss
);
    localparam int HW = (MAX_HALOS > 1) ? $clog2(MAX_HALOS) : 1;
    localparam int SW = (MAX_SUBHALOS > 1) ? $clog2(MAX_SUBHALOS) : 1;
    localparam int IW = (HW > SW) ? HW : SW;
    localparam int HN = (MAX_HALOS < SlotLimit) ? MAX_HALOS : SlotLimit;
    localparam int SN = (MAX_SUBHALOS < SlotLimit) ? MAX_SUBHALOS : SlotLimit;

    logic [159:0] halo_mem [MAX_HALOS];
    logic [135:0] sub_mem  [MAX_SUBHALOS];
    logic [31:0]  hit_mem  [HitDepth];
    logic [HitDepth-1:0] hit_valid_reg;

    // Query point and scan index
    logic [31:0] px_reg, py_reg, pz_reg;
    logic [IW:0] idx_reg, idx_next;
    logic [8:0]  hn_reg, sn_reg;
    logic [8:0]  hn_lim, sn_lim;

    always_comb
    begin
        hn_lim = (halo_count > 9'(HN)) ? 9'(HN) : halo_count;
        sn_lim = (subhalo_count > 9'(SN)) ? 9'(SN) : subhalo_count;
    end

    always_ff @(posedge clk)
    begin
        if (load_halo && (32'(entry_index) < 32'(MAX_HALOS)))
        begin
            halo_mem[HW'(entry_index)] <= {x_coord, y_coord, z_coord, radius, mass_or_parent};
        end
        if (load_sub && (32'(entry_index) < 32'(MAX_SUBHALOS)))
        begin
            sub_mem[SW'(entry_index)] <= {x_coord, y_coord, z_coord, radius,
                                          mass_or_parent[7:0]};
        end
        if (cmd.start)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
            pz_reg <= z_coord;
            hn_reg <= hn_lim;
            sn_reg <= sn_lim;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (cmd.step_halo || cmd.step_sub)
        begin
            idx_next = (cmd.step_halo && stat.halo_last) || (cmd.step_sub && stat.sub_last)
                       ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    assign stat.halo_last  = ((idx_reg + 1'b1) == (IW+1)'(hn_reg));
    assign stat.sub_last   = ((idx_reg + 1'b1) == (IW+1)'(sn_reg));
    assign stat.halo_empty = (hn_lim == '0);
    assign stat.sub_empty  = (sn_reg == '0);

    // Stage 1: table read
    logic         v1_reg, s1_sub_reg;
    logic [159:0] h1_reg;
    logic [135:0] u1_reg;
    logic [IW-1:0] i1_reg;
    always_ff @(posedge clk)
    begin
        h1_reg <= halo_mem[idx_reg[HW-1:0]];
        u1_reg <= sub_mem[idx_reg[SW-1:0]];
        i1_reg <= idx_reg[IW-1:0];
        s1_sub_reg <= cmd.step_sub;
    end

    // Stage 2: axis distances
    logic        v2_reg, s2_sub_reg;
    logic [31:0] dx2_reg, dy2_reg, dz2_reg, r2_reg, m2_reg;
    logic [IW-1:0] i2_reg;
    logic [31:0] ex, ey, ez, er, em;
    always_comb
    begin
        if (s1_sub_reg)
        begin
            {ex, ey, ez, er} = u1_reg[135:8];
            em = {24'd0, u1_reg[7:0]};
        end
        else
        begin
            {ex, ey, ez, er, em} = h1_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        dx2_reg <= axis_dist(ex, px_reg, box_size);
        dy2_reg <= axis_dist(ey, py_reg, box_size);
        dz2_reg <= axis_dist(ez, pz_reg, box_size);
        r2_reg  <= er;
        m2_reg  <= em;
        i2_reg  <= i1_reg;
        s2_sub_reg <= s1_sub_reg;
    end

    // Stage 3: squares
    logic        v3_reg, s3_sub_reg;
    logic [63:0] qx3_reg, qy3_reg, qz3_reg, qr3_reg;
    logic [31:0] m3_reg;
    logic [IW-1:0] i3_reg;
    always_ff @(posedge clk)
    begin
        qx3_reg <= 64'(dx2_reg) * 64'(dx2_reg);
        qy3_reg <= 64'(dy2_reg) * 64'(dy2_reg);
        qz3_reg <= 64'(dz2_reg) * 64'(dz2_reg);
        qr3_reg <= 64'(r2_reg) * 64'(r2_reg);
        m3_reg  <= m2_reg;
        i3_reg  <= i2_reg;
        s3_sub_reg <= s2_sub_reg;
    end

    // Stage 4: sum and compare
    logic        v4_reg, s4_sub_reg, in4_reg;
    logic [31:0] m4_reg;
    logic [IW-1:0] i4_reg;
    logic [65:0] sum3;
    always_comb
    begin
        sum3 = 66'(qx3_reg) + 66'(qy3_reg) + 66'(qz3_reg);
    end
    always_ff @(posedge clk)
    begin
        in4_reg <= (sum3 <= 66'(qr3_reg));
        m4_reg  <= m3_reg;
        i4_reg  <= i3_reg;
        s4_sub_reg <= s3_sub_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.step_halo || cmd.step_sub;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    // Selection
    logic        have_reg, have_next;
    logic [7:0]  best_reg, best_next;
    logic [31:0] bmass_reg, bmass_next;
    always_comb
    begin
        have_next  = have_reg;
        best_next  = best_reg;
        bmass_next = bmass_reg;
        if (cmd.start)
        begin
            have_next = 1'b0;
        end
        else if (v4_reg && in4_reg)
        begin
            if (!s4_sub_reg)
            begin
                if (!have_reg || m4_reg > bmass_reg)
                begin
                    have_next  = 1'b1;
                    best_next  = 8'(i4_reg);
                    bmass_next = m4_reg;
                end
            end
            else if (!have_reg || m4_reg[7:0] < best_reg)
            begin
                have_next = 1'b1;
                best_next = m4_reg[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end
    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        bmass_reg <= bmass_next;
    end
    assign stat.have = have_reg;

    // Hit counters: read in drain, written on finish
    logic [31:0] hit_rd_reg, miss_reg, hit_cur, hit_inc;
    always_ff @(posedge clk)
    begin
        hit_rd_reg <= hit_mem[best_reg];
        if (cmd.finish && have_reg)
        begin
            hit_mem[best_reg] <= hit_inc;
        end
    end
    assign hit_cur = hit_valid_reg[best_reg] ? hit_rd_reg : '0;
    assign hit_inc = (hit_cur == Sat32) ? hit_cur : hit_cur + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_valid_reg <= '0;
            miss_reg      <= '0;
        end
        else if (cmd.finish)
        begin
            if (have_reg)
            begin
                hit_valid_reg[best_reg] <= 1'b1;
            end
            else if (miss_reg != Sat32)
            begin
                miss_reg <= miss_reg + 32'd1;
            end
        end
    end

    assign res_found = have_reg;
    assign res_halo  = have_reg ? {1'b0, best_reg} : NoHalo;
    assign res_hits  = have_reg ? hit_inc : '0;
    assign res_miss  = (!have_reg && miss_reg != Sat32) ? miss_reg + 32'd1 : miss_reg;

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> v2_reg) else $error("pipeline lost an entry");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !stat.pipe_busy) else $error("finish with entries in flight");
    a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step_halo && cmd.step_sub)) else $error("both scans at once");
endmodule
`default_nettype wire

/* src/periodic_halo_membership_assigner_core.sv */
// Top level: APB registers, channel handshake, controller and datapath
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | in_valid/in_ready   | op, entry_index, x/y/z_coord, radius,
//           |                     | mass_or_parent
//  output   | out_valid/out_ready | found, owner_halo, halo_hits,
//           |                     | unassigned_total
//  config   | APB psel/penable    | box_size, halo_count, subhalo_count
//
// A query scans one entry per cycle through a four-stage containment pipeline and waits
// for it to empty after each scan. With h and s the counts capped at 256, the subhalo
// scan runs only when no halo holds the point and s is nonzero; with h zero the halo
// scan is skipped.
// The result sits in an output register; the next item is taken while it waits,
// and a following query finishes only after that result is transferred.
// Reset is asynchronous and clears the hit counters through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module periodic_halo_membership_assigner_core
    import phma_pkg::*;
#(
    parameter int MAX_HALOS    = DefMaxHalos,
    parameter int MAX_SUBHALOS = DefMaxSubhalos
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  entry_index,
    input  wire logic [31:0] x_coord,
    input  wire logic [31:0] y_coord,
    input  wire logic [31:0] z_coord,
    input  wire logic [31:0] radius,
    input  wire logic [31:0] mass_or_parent,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [8:0]       owner_halo,
    output logic [31:0]      halo_hits,
    output logic [31:0]      unassigned_total
);
    logic [31:0] box_reg;
    logic [8:0]  hcnt_reg, scnt_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg  <= Sat32;
            hcnt_reg <= '0;
            scnt_reg <= '0;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_BOX:  box_reg  <= pwdata;
                REG_HALO: hcnt_reg <= pwdata[8:0];
                REG_SUB:  scnt_reg <= pwdata[8:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BOX:  prdata = box_reg;
            REG_HALO: prdata = {23'd0, hcnt_reg};
            REG_SUB:  prdata = {23'd0, scnt_reg};
            default:  prdata = '0;
        endcase
    end

    phma_cmd_t  cmd;
    phma_stat_t stat;
    logic       busy, acc, out_free;
    logic       r_found;
    logic [8:0] r_halo;
    logic [31:0] r_hits, r_miss;

    assign in_ready = !busy;
    assign acc      = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;

    phma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .query_go (acc && (op == OP_QUERY)),
        .stat     (stat),
        .out_free (out_free),
        .cmd      (cmd),
        .busy     (busy)
    );

    phma_dp #(
        .MAX_HALOS    (MAX_HALOS),
        .MAX_SUBHALOS (MAX_SUBHALOS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .load_halo      (acc && (op == OP_LOAD_HALO)),
        .load_sub       (acc && (op == OP_LOAD_SUB)),
        .entry_index    (entry_index),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .z_coord        (z_coord),
        .radius         (radius),
        .mass_or_parent (mass_or_parent),
        .box_size       (box_reg),
        .halo_count     (hcnt_reg),
        .subhalo_count  (scnt_reg),
        .cmd            (cmd),
        .stat           (stat),
        .res_found      (r_found),
        .res_halo       (r_halo),
        .res_hits       (r_hits),
        .res_miss       (r_miss)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            found            <= r_found;
            owner_halo       <= r_halo;
            halo_hits        <= r_hits;
            unassigned_total <= r_miss;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.finish) else $error("result overwritten");
    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (owner_halo == NoHalo && halo_hits == '0))
        else $error("bad unassigned result");
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("input taken while busy");
endmodule
`default_nettype wire
